// File: hdl/ifdd_pkg.sv
// ifdd_pkg: constants, types and field helpers for the imu frame deframer and decoder
// depends on nothing; used by ifdd_window, ifdd_decode and imu_frame_deframe_decode
`timescale 1ns / 1ps

package ifdd_pkg;

	localparam int unsigned FrameLen    = 22;
	localparam int unsigned DecodeBytes = 20;
	localparam int unsigned CountW      = 5;
	localparam logic [7:0]  Newline     = 8'h0A;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic                         hit;
		logic [DecodeBytes-1:0][7:0]  data;
	} frame_t;

	function automatic logic signed [11:0] word12(input byte_t hi, input byte_t lo);
		word12 = {hi[3:0], lo};
	endfunction

	function automatic logic signed [13:0] word14(input byte_t hi, input byte_t lo);
		word14 = {hi[5:0], lo};
	endfunction

endpackage

// File: hdl/imu_frame_deframe_decode.sv
// imu_frame_deframe_decode: top level of the imu byte-stream deframer and sample decoder
// depends on ifdd_pkg, ifdd_window and ifdd_decode
//
//   channel  | handshake                   | payload
//   rx       | rx_valid / rx_ready         | rx_byte
//   sample   | sample_valid / sample_ready | supply_raw, gyro_*, accel_*, temp_*
//
// one byte is taken every cycle while rx_ready is high; a newline beat passes through the input
// register and then the result register, which sets sample_valid
// reset clears the window, the byte counter and both valid flags
// a stalled sample holds the result register; the input register still takes a byte
// whenever it is empty or moving on
`timescale 1ns / 1ps

module imu_frame_deframe_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	output logic                 sample_valid,
	input  logic                 sample_ready,
	output logic signed [11:0]   supply_raw,
	output logic signed [13:0]   gyro_x,
	output logic signed [13:0]   gyro_y,
	output logic signed [13:0]   gyro_z,
	output logic signed [13:0]   accel_x,
	output logic signed [13:0]   accel_y,
	output logic signed [13:0]   accel_z,
	output logic signed [11:0]   temp_x,
	output logic signed [11:0]   temp_y,
	output logic signed [11:0]   temp_z
);
	import ifdd_pkg::*;

	frame_t frame;
	logic   free;

	ifdd_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.rx_byte  (rx_byte),
		.free     (free),
		.frame    (frame)
	);

	ifdd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame),
		.free         (free),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.supply_raw   (supply_raw),
		.gyro_x       (gyro_x),
		.gyro_y       (gyro_y),
		.gyro_z       (gyro_z),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.temp_x       (temp_x),
		.temp_y       (temp_y),
		.temp_z       (temp_z)
	);

endmodule

// File: hdl/ifdd_window.sv
// ifdd_window: input register, 22-byte shift window and saturating byte counter
// flags a completed frame; depends on ifdd_pkg
`timescale 1ns / 1ps

module ifdd_window (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rx_valid,
	output logic                     rx_ready,
	input  ifdd_pkg::byte_t          rx_byte,
	input  logic                     free,
	output ifdd_pkg::frame_t         frame
);
	import ifdd_pkg::*;

	logic                        valid_s1;
	byte_t                       byte_s1;
	logic [FrameLen-1:0][7:0]    win_q;
	logic [CountW-1:0]           count_q;
	logic                        adv;
	logic                        is_nl;

	assign adv      = valid_s1 && free;
	assign rx_ready = !valid_s1 || free;
	assign is_nl    = (byte_s1 == Newline);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			count_q <= '0;
		end else if (adv) begin
			if (is_nl) begin
				count_q <= '0;
			end else begin
				for (int i = 0; i < FrameLen - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[FrameLen-1] <= byte_s1;
				if (count_q != CountMax) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		frame.hit = valid_s1 && is_nl && (count_q >= CountW'(FrameLen));
		for (int i = 0; i < DecodeBytes; i++) begin
			frame.data[i] = win_q[i];
		end
	end

endmodule

// File: hdl/ifdd_decode.sv
// ifdd_decode: splits a completed frame into ten signed words and holds them
// in the result register with its handshake; depends on ifdd_pkg
`timescale 1ns / 1ps

module ifdd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ifdd_pkg::frame_t     frame,
	output logic                 free,
	output logic                 sample_valid,
	input  logic                 sample_ready,
	output logic signed [11:0]   supply_raw,
	output logic signed [13:0]   gyro_x,
	output logic signed [13:0]   gyro_y,
	output logic signed [13:0]   gyro_z,
	output logic signed [13:0]   accel_x,
	output logic signed [13:0]   accel_y,
	output logic signed [13:0]   accel_z,
	output logic signed [11:0]   temp_x,
	output logic signed [11:0]   temp_y,
	output logic signed [11:0]   temp_z
);
	import ifdd_pkg::*;

	logic                valid_q;
	logic signed [11:0]  supply_q;
	logic signed [13:0]  gx_q, gy_q, gz_q, ax_q, ay_q, az_q;
	logic signed [11:0]  tx_q, ty_q, tz_q;
	logic                load;

	assign free = !valid_q || sample_ready;
	assign load = free && frame.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= frame.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			supply_q <= word12(frame.data[0],  frame.data[1]);
			gx_q     <= word14(frame.data[2],  frame.data[3]);
			gy_q     <= word14(frame.data[4],  frame.data[5]);
			gz_q     <= word14(frame.data[6],  frame.data[7]);
			ax_q     <= word14(frame.data[8],  frame.data[9]);
			ay_q     <= word14(frame.data[10], frame.data[11]);
			az_q     <= word14(frame.data[12], frame.data[13]);
			tx_q     <= word12(frame.data[14], frame.data[15]);
			ty_q     <= word12(frame.data[16], frame.data[17]);
			tz_q     <= word12(frame.data[18], frame.data[19]);
		end
	end

	assign sample_valid = valid_q;
	assign supply_raw   = supply_q;
	assign gyro_x       = gx_q;
	assign gyro_y       = gy_q;
	assign gyro_z       = gz_q;
	assign accel_x      = ax_q;
	assign accel_y      = ay_q;
	assign accel_z      = az_q;
	assign temp_x       = tx_q;
	assign temp_y       = ty_q;
	assign temp_z       = tz_q;

endmodule

// File: tb/imu_frame_deframe_decode_test.sv
// imu_frame_deframe_decode_test: self-checking bench for the imu frame deframer and decoder
// depends on ifdd_pkg and imu_frame_deframe_decode; a table of frames, then random byte streams,
// in four idle/stall mixes, checked by an in-bench window/counter predictor or typed rows
`timescale 1ns / 1ps

module imu_frame_deframe_decode_test;
	import ifdd_pkg::*;

	typedef struct packed {
		logic signed [11:0] supply;
		logic signed [13:0] gx;
		logic signed [13:0] gy;
		logic signed [13:0] gz;
		logic signed [13:0] ax;
		logic signed [13:0] ay;
		logic signed [13:0] az;
		logic signed [11:0] tx;
		logic signed [11:0] ty;
		logic signed [11:0] tz;
	} sample_t;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_e;

	typedef struct packed {
		logic [5:0]  len;
		byte_t       first;
		byte_t       second;
		logic        ramp;
		chk_e        mode;
		logic [11:0] exp12;
		logic [13:0] exp14;
	} frame_case_t;

	localparam int NumCases = 18;
	// typed rows: every 12-bit field takes exp12, every 14-bit field exp14
	localparam frame_case_t FrameCases [NumCases] = '{
		'{6'd0,  8'h00, 8'h00, 1'b0, CHK_NONE,  12'h000, 14'h0000},
		'{6'd22, 8'h00, 8'h00, 1'b0, CHK_TYPED, 12'h000, 14'h0000},
		'{6'd22, 8'hFF, 8'hFF, 1'b0, CHK_TYPED, 12'hFFF, 14'h3FFF},
		'{6'd0,  8'h00, 8'h00, 1'b0, CHK_NONE,  12'h000, 14'h0000},
		'{6'd22, 8'h20, 8'h00, 1'b0, CHK_TYPED, 12'h000, 14'h2000},
		'{6'd22, 8'h1F, 8'hFF, 1'b0, CHK_TYPED, 12'hFFF, 14'h1FFF},
		'{6'd22, 8'h08, 8'h00, 1'b0, CHK_TYPED, 12'h800, 14'h0800},
		'{6'd22, 8'h07, 8'hFF, 1'b0, CHK_TYPED, 12'h7FF, 14'h07FF},
		'{6'd22, 8'hC0, 8'h00, 1'b0, CHK_TYPED, 12'h000, 14'h0000},
		'{6'd22, 8'hF0, 8'h00, 1'b0, CHK_TYPED, 12'h000, 14'h3000},
		'{6'd21, 8'h55, 8'hAA, 1'b0, CHK_NONE,  12'h000, 14'h0000},
		'{6'd22, 8'hAA, 8'h55, 1'b0, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd23, 8'h12, 8'h34, 1'b0, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd31, 8'h40, 8'h00, 1'b1, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd40, 8'h80, 8'h00, 1'b1, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd22, 8'h41, 8'h0A, 1'b0, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd22, 8'h0B, 8'h09, 1'b0, CHK_MODEL, 12'h000, 14'h0000},
		'{6'd22, 8'hF0, 8'h00, 1'b1, CHK_MODEL, 12'h000, 14'h0000}
	};

	localparam byte_t EdgeBytes [10] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h20,
		8'h1F, 8'h08, 8'h07, 8'hC0, 8'h3F};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic rx_ready;
	logic [7:0] rx_byte = 8'h00;
	logic sample_valid;
	logic sample_ready = 1'b0;
	logic signed [11:0] supply_raw;
	logic signed [13:0] gyro_x, gyro_y, gyro_z;
	logic signed [13:0] accel_x, accel_y, accel_z;
	logic signed [11:0] temp_x, temp_y, temp_z;

	imu_frame_deframe_decode dut (.*);

	byte_t window_q [FrameLen] = '{default: 8'h00};
	logic [CountW-1:0] since_newline = '0;
	sample_t pending_samples [$];
	sample_t oldest;
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int samples_due = 0;
	int samples_seen = 0;
	int errors = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		sample_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic sample_t typed_sample(input logic [11:0] f12, input logic [13:0] f14);
		sample_t s;
		s = '{f12, f14, f14, f14, f14, f14, f14, f12, f12, f12};
		return s;
	endfunction

	// window shift and saturating count; returns 1 when a sample is due
	function automatic bit deframe_byte(input byte_t b, output sample_t s);
		logic [15:0] w [10];
		bit full;
		s = '0;
		if (b == Newline) begin
			full = (since_newline >= FrameLen);
			since_newline = '0;
			if (!full)
				return 1'b0;
			for (int k = 0; k < 10; k++)
				w[k] = {window_q[2*k], window_q[2*k+1]};
			s = '{w[0][11:0], w[1][13:0], w[2][13:0], w[3][13:0], w[4][13:0], w[5][13:0],
				w[6][13:0], w[7][11:0], w[8][11:0], w[9][11:0]};
			return 1'b1;
		end
		for (int i = 0; i < FrameLen - 1; i++)
			window_q[i] = window_q[i+1];
		window_q[FrameLen-1] = b;
		if (since_newline != CountMax)
			since_newline = since_newline + 1'b1;
		return 1'b0;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic signed [15:0] e,
		input logic signed [15:0] a);
		if (a !== e)
			flag_error($sformatf("sample %0d %s expected %0d got %0d", samples_seen, name, e, a));
	endtask

	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready) begin
			if (pending_samples.size() == 0) begin
				flag_error($sformatf("sample %0d arrived with nothing pending", samples_seen));
			end else begin
				oldest = pending_samples.pop_front();
				check_field("supply_raw", oldest.supply, supply_raw);
				check_field("gyro_x", oldest.gx, gyro_x);
				check_field("gyro_y", oldest.gy, gyro_y);
				check_field("gyro_z", oldest.gz, gyro_z);
				check_field("accel_x", oldest.ax, accel_x);
				check_field("accel_y", oldest.ay, accel_y);
				check_field("accel_z", oldest.az, accel_z);
				check_field("temp_x", oldest.tx, temp_x);
				check_field("temp_y", oldest.ty, temp_y);
				check_field("temp_z", oldest.tz, temp_z);
			end
			samples_seen++;
		end
	end

	// one rx beat, with a random sender gap in front
	task automatic put_byte(input byte_t b, input chk_e mode, input sample_t typed);
		sample_t s;
		bit got;
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		bytes_sent++;
		got = deframe_byte(b, s);
		if (mode == CHK_TYPED) begin
			pending_samples.push_back(typed);
			samples_due++;
		end else if (mode == CHK_MODEL && got) begin
			pending_samples.push_back(s);
			samples_due++;
		end
	endtask

	task automatic send_frame(input int len, input byte_t first, input byte_t second,
		input bit ramp, input chk_e mode, input sample_t typed);
		byte_t b;
		for (int i = 0; i < len; i++) begin
			b = ramp ? byte_t'(first + i) : ((i % 2) ? second : first);
			put_byte(b, CHK_MODEL, '0);
		end
		put_byte(Newline, mode, typed);
	endtask

	task automatic send_random_burst();
		int kind;
		int len;
		byte_t b;
		kind = $urandom_range(19);
		if (kind >= 17) begin
			repeat ($urandom_range(8, 1)) begin
				b = ($urandom_range(99) < 30) ? Newline : byte_t'($urandom_range(255));
				put_byte(b, CHK_MODEL, '0);
			end
			return;
		end
		if (kind <= 14)
			len = FrameLen;
		else if (kind == 15)
			len = $urandom_range(45, 23);
		else
			len = $urandom_range(21, 0);
		for (int i = 0; i < len; i++) begin
			if (kind == 13 || kind == 14)
				b = EdgeBytes[$urandom_range(9)];
			else
				b = byte_t'($urandom_range(255));
			put_byte(b, CHK_MODEL, '0);
		end
		put_byte(Newline, CHK_MODEL, '0);
	endtask

	initial begin
		int phase_idle [4];
		int phase_stall [4];
		int start_bytes;
		int start_due;
		phase_idle = '{0, 71, 0, 30};
		phase_stall = '{0, 0, 71, 30};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NumCases; r++)
			send_frame(FrameCases[r].len, FrameCases[r].first, FrameCases[r].second,
				FrameCases[r].ramp, FrameCases[r].mode,
				typed_sample(FrameCases[r].exp12, FrameCases[r].exp14));

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_idle[p];
			stall_pct = phase_stall[p];
			start_bytes = bytes_sent;
			start_due = samples_due;
			while (bytes_sent - start_bytes < 85 || samples_due - start_due < 3)
				send_random_burst();
		end
		rx_valid <= 1'b0;

		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d bytes sent, %0d samples checked, %0d mismatches",
			bytes_sent, samples_seen, errors);
		$display("field extremes, short/long/broken frames, random streams in four idle mixes");
		if (errors == 0 && pending_samples.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: files.f
hdl/ifdd_pkg.sv
hdl/ifdd_window.sv
hdl/ifdd_decode.sv
hdl/imu_frame_deframe_decode.sv
tb/imu_frame_deframe_decode_test.sv
